[design/svrd_pkg.sv]
// Shared types and constants for the stuffed varint record deframer.
// No dependencies; used by svrd_decode, svrd_out_reg and the top level.
package svrd_pkg;

  localparam logic [7:0] ByteStart  = 8'd250;
  localparam logic [7:0] ByteEscape = 8'd249;
  localparam logic [7:0] IdRawLo    = 8'd96;
  localparam logic [7:0] IdRawHi    = 8'd98;
  localparam logic [7:0] EscStart   = 8'd0;
  localparam logic [7:0] EscEscape  = 8'd1;
  localparam int unsigned DataBits  = 7;

  typedef enum logic [1:0] {
    KIND_WORD = 2'd0,
    KIND_RAW  = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  record_id;
    logic [31:0] value;
    logic        overflow;
  } result_t;

  function automatic logic id_is_raw(input logic [7:0] id);
    id_is_raw = (id >= IdRawLo) && (id <= IdRawHi);
  endfunction

endpackage

[design/svrd_in_reg.sv]
// Input register of the deframer: holds one stream byte until the decoder takes it.
// Depends on nothing but the clock and reset.
module svrd_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] log_byte_i,
  input  logic       advance_i,
  output logic       byte_valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= log_byte_i;
    end
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

endmodule

[design/svrd_decode.sv]
// Destuffing, record framing and varint decode; holds the record state.
// Depends on svrd_pkg for codes, the result type and the raw-id check.
module svrd_decode #(
  parameter int unsigned MAX_WORDS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic [7:0]          byte_i,
  output logic                res_valid_o,
  output svrd_pkg::result_t   res_o
);

  localparam int unsigned CntW = $clog2(MAX_WORDS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_WORDS);

  logic            esc_q, esc_d;
  logic            id_pend_q, id_pend_d;
  logic [7:0]      cur_id_q, cur_id_d;
  logic [31:0]     acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;

  logic            pay_valid;
  logic [7:0]      pay_byte;
  logic [31:0]     acc_next;
  logic            ovf_next;

  // Destuff: decide whether this byte yields a payload byte.
  always_comb begin
    esc_d     = esc_q;
    pay_valid = 1'b0;
    pay_byte  = byte_i;
    if (byte_i == svrd_pkg::ByteStart) begin
      pay_valid = 1'b0;
    end else if (byte_i == svrd_pkg::ByteEscape) begin
      esc_d = 1'b1;
    end else if (esc_q) begin
      esc_d = 1'b0;
      if (byte_i == svrd_pkg::EscStart) begin
        pay_valid = 1'b1;
        pay_byte  = svrd_pkg::ByteStart;
      end else if (byte_i == svrd_pkg::EscEscape) begin
        pay_valid = 1'b1;
        pay_byte  = svrd_pkg::ByteEscape;
      end
    end else begin
      pay_valid = 1'b1;
    end
  end

  assign acc_next = {acc_q[31-svrd_pkg::DataBits:0], pay_byte[svrd_pkg::DataBits-1:0]};
  assign ovf_next = ovf_q || (cnt_q >= MaxCnt);

  always_comb begin
    id_pend_d   = id_pend_q;
    cur_id_d    = cur_id_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    res_valid_o = 1'b0;
    res_o.kind      = svrd_pkg::KIND_WORD;
    res_o.record_id = cur_id_q;
    res_o.value     = acc_next;
    res_o.overflow  = ovf_next;
    if (byte_i == svrd_pkg::ByteStart) begin
      // Close the open decoded record with its word count.
      if (!id_pend_q && (cur_id_q != 8'd0) && !svrd_pkg::id_is_raw(cur_id_q)) begin
        res_valid_o    = 1'b1;
        res_o.kind     = svrd_pkg::KIND_END;
        res_o.value    = 32'(cnt_q);
        res_o.overflow = ovf_q;
      end
      id_pend_d = 1'b1;
      acc_d     = '0;
      cnt_d     = '0;
      ovf_d     = 1'b0;
    end else if (pay_valid) begin
      if (id_pend_q) begin
        cur_id_d  = pay_byte;
        id_pend_d = 1'b0;
      end else if (cur_id_q == 8'd0) begin
        res_valid_o = 1'b0;
      end else if (svrd_pkg::id_is_raw(cur_id_q)) begin
        res_valid_o    = 1'b1;
        res_o.kind     = svrd_pkg::KIND_RAW;
        res_o.value    = {24'd0, pay_byte};
        res_o.overflow = 1'b0;
      end else if (pay_byte[7]) begin
        acc_d = acc_next;
      end else begin
        // Word complete: count it, saturating at the limit.
        res_valid_o = 1'b1;
        acc_d       = '0;
        ovf_d       = ovf_next;
        if (cnt_q < MaxCnt) begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q     <= 1'b0;
      id_pend_q <= 1'b0;
      cur_id_q  <= '0;
      acc_q     <= '0;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
    end else if (advance_i) begin
      esc_q     <= esc_d;
      id_pend_q <= id_pend_d;
      cur_id_q  <= cur_id_d;
      acc_q     <= acc_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
    end
  end

endmodule

[design/svrd_out_reg.sv]
// Result register of the deframer: holds one result until the consumer takes it.
// Depends on svrd_pkg for the result type.
module svrd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  svrd_pkg::result_t res_i,
  output logic              free_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output svrd_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  svrd_pkg::result_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

[design/stuffed_varint_record_deframer.sv]
// Top level of the stuffed varint record deframer.
// Depends on svrd_pkg, svrd_in_reg, svrd_decode and svrd_out_reg.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-----------------------------------------
//   input    | in_valid_i / in_ready_o | log_byte_i
//   output   | out_valid_o/out_ready_i | kind_o, record_id_o, value_o, overflow_o
//
// One byte per cycle unless the output stalls: input register, one pass of
// decode logic, result register. A result is loaded as its byte advances; bytes
// with no result just update the record state. Reset clears the escape, id,
// accumulator and count state. A stalled output holds the decoder and the held
// byte, and in_ready_o drops in that same cycle while the input register is full.
module stuffed_varint_record_deframer #(
  parameter int unsigned MAX_WORDS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  log_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  record_id_o,
  output logic [31:0] value_o,
  output logic        overflow_o
);

  logic              byte_valid;
  logic [7:0]        byte_q;
  logic              out_free;
  logic              advance;
  logic              res_valid;
  svrd_pkg::result_t res;
  svrd_pkg::result_t out_res;

  // Advance the held byte once the result register can take its result.
  assign advance = byte_valid && out_free;

  svrd_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .log_byte_i   (log_byte_i),
    .advance_i    (advance),
    .byte_valid_o (byte_valid),
    .byte_o       (byte_q)
  );

  svrd_decode #(
    .MAX_WORDS (MAX_WORDS)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .byte_i      (byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  svrd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign kind_o      = out_res.kind;
  assign record_id_o = out_res.record_id;
  assign value_o     = out_res.value;
  assign overflow_o  = out_res.overflow;

endmodule
